// File: hw/rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear probe hash table
// Status codes, command kinds, state encodings and the queued command record.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned SKEY_W   = 31;    // stored keys are positive
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned STAT_W   = 4;
    localparam int unsigned START_W  = 16;    // covers the largest slot index
    localparam int unsigned DIV_W    = 33;    // 3*key
    localparam int unsigned DCNT_W   = 6;
    localparam int unsigned MIN_SIZE = 17;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIND  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SCAN  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE        = 4'd0,
        ST_OVERWRITTEN = 4'd1,
        ST_INSERTED    = 4'd2,
        ST_FOUND       = 4'd3,
        ST_NOT_FOUND   = 4'd4,
        ST_BAD_KEY     = 4'd5,
        ST_ZERO_DATA   = 4'd6,
        ST_LOAD_LIMIT  = 4'd7,
        ST_TABLE_FULL  = 4'd8,
        ST_SCAN_END    = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_FIND,
        CMD_CLEAR,
        CMD_SCAN,
        CMD_REPORT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        status_t             status;   // used by CMD_REPORT
        logic [SKEY_W-1:0]   key;
        logic [DATA_W-1:0]   data;
        logic [START_W-1:0]  start;    // home slot or scan position
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_READ,
        B_EVAL,
        B_CLEAR
    } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lph_if.sv
// ----------------------------------------------------------------------------
// lph_if: channel interfaces for the linear probe hash table
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lph_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         op;
    logic signed [lph_pkg::KEY_W-1:0]   key;
    logic signed [lph_pkg::DATA_W-1:0]  data_in;
    logic [lph_pkg::POS_W-1:0]          position;

    modport source (output valid, op, key, data_in, position, input ready);
    modport sink   (input valid, op, key, data_in, position, output ready);
endinterface

interface lph_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [lph_pkg::STAT_W-1:0]         status;
    logic signed [lph_pkg::DATA_W-1:0]  data_out;
    logic [lph_pkg::SKEY_W-1:0]         key_out;
    logic [lph_pkg::POS_W-1:0]          slot_out;
    logic [lph_pkg::SIZE_W-1:0]         entry_count;

    modport source (output valid, status, data_out, key_out, slot_out, entry_count,
                    input ready);
    modport sink   (input valid, status, data_out, key_out, slot_out, entry_count,
                    output ready);
endinterface

interface lph_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lph_pkg::SIZE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front: request intake and classification
// Checks arguments, computes the home slot with a bit-serial modulo unit and
// pushes one command per transaction into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lph_pkg::SIZE_W-1:0]  size,
    lph_req_if.sink                          req,
    output lph_pkg::cmd_t                    q_cmd,
    output logic                             q_push,
    input  wire logic                        q_full
);
    import lph_pkg::*;

    front_state_t          state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [SIZE_W:0]       trial;
    logic [SIZE_W:0]       trial_sub;
    logic                  accept;
    logic                  need_hash;
    cmd_t                  cls;
    logic [SKEY_W-1:0]     pkey;

    assign accept = req.valid && req.ready;
    assign pkey   = req.key[SKEY_W-1:0];

    // classification of an incoming transaction
    always_comb
    begin
        cls        = '0;
        cls.key    = pkey;
        cls.data   = req.data_in;
        cls.start  = START_W'(req.position);
        cls.kind   = CMD_REPORT;
        cls.status = ST_DONE;
        need_hash  = 1'b0;
        case (op_t'(req.op))
            OP_ADD:
            begin
                if (req.key == '0 || req.key[KEY_W-1])
                    cls.status = ST_BAD_KEY;
                else if (req.data_in == '0)
                    cls.status = ST_ZERO_DATA;
                else
                begin
                    cls.kind  = CMD_ADD;
                    need_hash = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (req.key == '0)
                    cls.status = ST_BAD_KEY;
                else if (req.key[KEY_W-1])
                    cls.status = ST_NOT_FOUND;
                else
                begin
                    cls.kind  = CMD_FIND;
                    need_hash = 1'b1;
                end
            end
            OP_CLEAR:
                cls.kind = CMD_CLEAR;
            OP_SCAN:
            begin
                if ({1'b0, req.position} >= size)
                    cls.status = ST_SCAN_END;
                else
                    cls.kind = CMD_SCAN;
            end
            default:
                cls.kind = CMD_REPORT;
        endcase
    end

    // one quotient bit per cycle
    assign trial     = {rem_reg, div_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, size};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = need_hash ? F_HASH : F_PUSH;
            F_HASH:
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                    state_next = F_PUSH;
            F_PUSH:
                if (!q_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            F_IDLE:
                if (accept)
                begin
                    cmd_next = cls;
                    div_next = {2'b00, pkey} + {1'b0, pkey, 1'b0};
                    rem_next = '0;
                    cnt_next = '0;
                end
            F_HASH:
            begin
                rem_next = (trial >= {1'b0, size}) ? trial_sub[SIZE_W-1:0]
                                                   : trial[SIZE_W-1:0];
                div_next = {div_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                    cmd_next.start = START_W'(rem_next);
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    assign req.ready = (state_reg == F_IDLE);
    assign q_push    = (state_reg == F_PUSH) && !q_full;
    assign q_cmd     = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lph_cmd_queue.sv
// ----------------------------------------------------------------------------
// lph_cmd_queue: two-entry command queue
// Decouples the front end from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lph_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output lph_pkg::cmd_t       head
);
    import lph_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);

    cmd_t              slot_reg [DEPTH];
    logic [PW-1:0]     wr_reg, wr_next;
    logic [PW-1:0]     rd_reg, rd_next;
    logic [PW:0]       cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back: table engine
// Owns the slot memory and entry count; runs probes, scans and clear sweeps
// and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_back #(
    parameter int unsigned SLOTS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lph_pkg::SIZE_W-1:0]  size,
    input  wire logic [lph_pkg::SIZE_W-1:0]  limit,
    input  wire logic                        q_valid,
    input  wire lph_pkg::cmd_t               q_cmd,
    output logic                             q_pop,
    lph_rsp_if.source                        rsp
);
    import lph_pkg::*;

    localparam int unsigned IW      = $clog2(SLOTS);
    localparam int unsigned CW      = ((IW > SIZE_W) ? IW : SIZE_W) + 1;
    localparam int unsigned ENTRY_W = 1 + SKEY_W + DATA_W;
    localparam int unsigned MAXSZ   = (SLOTS > 2047) ? 2047 : SLOTS;

    // entry layout: {occupied, key, data}
    logic [ENTRY_W-1:0]  mem [SLOTS];
    logic [ENTRY_W-1:0]  rd_data_reg;

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [IW-1:0]       h_reg, h_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [SIZE_W-1:0]   count_reg, count_next;

    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [SKEY_W-1:0]   out_key_reg;
    logic [POS_W-1:0]    out_slot_reg;
    logic [SIZE_W-1:0]   out_count_reg;

    logic                load;
    status_t             o_status;
    logic [DATA_W-1:0]   o_data;
    logic [SKEY_W-1:0]   o_key;
    logic [POS_W-1:0]    o_slot;

    logic                e_occ;
    logic [SKEY_W-1:0]   e_key;
    logic [DATA_W-1:0]   e_data;
    logic                e_match;
    logic                h_last;
    logic                i_last;
    logic                sweep_last;
    logic                take;

    assign e_occ      = rd_data_reg[ENTRY_W-1];
    assign e_key      = rd_data_reg[DATA_W +: SKEY_W];
    assign e_data     = rd_data_reg[DATA_W-1:0];
    assign e_match    = e_occ && (e_key == cmd_reg.key);
    assign h_last     = (CW'(h_reg) == CW'(size) - CW'(1));
    assign i_last     = (i_reg + CW'(1) == CW'(size));
    assign sweep_last = (h_reg == IW'(SLOTS - 1));
    assign take       = q_valid && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_INIT:
                if (sweep_last)
                    state_next = B_IDLE;
            B_IDLE:
                if (take)
                begin
                    case (q_cmd.kind)
                        CMD_REPORT: state_next = B_IDLE;
                        CMD_CLEAR:  state_next = B_CLEAR;
                        default:    state_next = B_READ;
                    endcase
                end
            B_READ:
                state_next = B_EVAL;
            B_EVAL:
            begin
                case (cmd_reg.kind)
                    CMD_ADD, CMD_FIND:
                        state_next = (e_match || !e_occ || i_last) ? B_IDLE : B_READ;
                    CMD_SCAN:
                        state_next = (e_occ || h_last) ? B_IDLE : B_READ;
                    default:
                        state_next = B_IDLE;
                endcase
            end
            B_CLEAR:
                if (sweep_last)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        h_next     = h_reg;
        i_next     = i_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_data    = '0;
        q_pop      = 1'b0;
        load       = 1'b0;
        o_status   = ST_DONE;
        o_data     = '0;
        o_key      = '0;
        o_slot     = '0;
        case (state_reg)
            B_INIT:
            begin
                wr_en  = 1'b1;
                h_next = h_reg + IW'(1);
            end
            B_IDLE:
                if (take)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    h_next   = IW'(q_cmd.start);
                    i_next   = '0;
                    if (q_cmd.kind == CMD_CLEAR)
                        h_next = '0;
                    if (q_cmd.kind == CMD_REPORT)
                    begin
                        load     = 1'b1;
                        o_status = q_cmd.status;
                    end
                end
            B_EVAL:
            begin
                case (cmd_reg.kind)
                    CMD_ADD:
                    begin
                        if (e_match)
                        begin
                            wr_en    = 1'b1;
                            wr_data  = {1'b1, cmd_reg.key, cmd_reg.data};
                            load     = 1'b1;
                            o_status = ST_OVERWRITTEN;
                            o_slot   = POS_W'(h_reg);
                        end
                        else if (!e_occ)
                        begin
                            load = 1'b1;
                            if (count_reg >= limit)
                                o_status = ST_LOAD_LIMIT;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = {1'b1, cmd_reg.key, cmd_reg.data};
                                count_next = count_reg + SIZE_W'(1);
                                o_status   = ST_INSERTED;
                                o_slot     = POS_W'(h_reg);
                            end
                        end
                        else if (i_last)
                        begin
                            load     = 1'b1;
                            o_status = ST_TABLE_FULL;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (e_match)
                        begin
                            load     = 1'b1;
                            o_status = ST_FOUND;
                            o_data   = e_data;
                            o_slot   = POS_W'(h_reg);
                        end
                        else if (!e_occ || i_last)
                        begin
                            load     = 1'b1;
                            o_status = ST_NOT_FOUND;
                        end
                    end
                    CMD_SCAN:
                    begin
                        if (e_occ)
                        begin
                            load     = 1'b1;
                            o_status = ST_FOUND;
                            o_data   = e_data;
                            o_key    = e_key;
                            o_slot   = POS_W'(h_reg);
                        end
                        else if (h_last)
                        begin
                            load     = 1'b1;
                            o_status = ST_SCAN_END;
                        end
                    end
                    default:
                        load = 1'b0;
                endcase
                // next probe: wrap for hashed ops, none for scan
                if (cmd_reg.kind == CMD_SCAN)
                    h_next = h_reg + IW'(1);
                else
                    h_next = h_last ? '0 : h_reg + IW'(1);
                i_next = i_reg + CW'(1);
                if (wr_en)
                    h_next = h_reg;
            end
            B_CLEAR:
            begin
                wr_en  = 1'b1;
                h_next = h_reg + IW'(1);
                if (sweep_last)
                begin
                    count_next = '0;
                    load       = 1'b1;
                    o_status   = ST_DONE;
                end
            end
            default:
                load = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[h_reg] <= wr_data;
        rd_data_reg <= mem[h_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            h_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            count_reg <= count_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        i_reg   <= i_next;
        if (load)
        begin
            out_status_reg <= o_status;
            out_data_reg   <= o_data;
            out_key_reg    <= o_key;
            out_slot_reg   <= o_slot;
            out_count_reg  <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.slot_out    = out_slot_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SIZE_W'(MAXSZ))
        else $error("entry count above table capacity");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |-> (CW'(h_reg) < CW'(size)))
        else $error("probe outside active slots");

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg)
        else $error("command taken while result pending");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR && sweep_last) |=> (count_reg == '0 && out_valid_reg))
        else $error("clear did not empty count");

endmodule

`default_nettype wire

// File: hw/rtl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open addressing key/data map
// Front end classifies and hashes requests, a command queue decouples it from
// the table engine that probes the slot memory and returns one result each.
// ----------------------------------------------------------------------------
// Operation: add/find compute (3*key) mod size bit-serially in the front end,
//   then each probed slot takes a memory read, then a compare.
// Scan reads and compares each slot visited; clear writes all SLOTS slots (one
//   slot per cycle through the single memory write port); rejects skip the memory.
// Throughput: one item at a time per side; the front end hashes the next item
//   while the engine works on the previous one.
// Reset: a clearing pass over all SLOTS slots empties the memory; commands wait in
//   the queue meanwhile. table_size resets to 1024.
`default_nettype none

module linear_probe_hash_table_top #(
    parameter int unsigned SLOTS = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lph_req_if.sink    req,
    lph_rsp_if.source  rsp,
    lph_cfg_if.sink    cfg
);
    import lph_pkg::*;

    // largest size the 11-bit register can express within the store
    localparam int unsigned MAXSZ = (SLOTS > 2047) ? 2047 : SLOTS;
    // size/6 as (size*683)>>12, exact for sizes below 2048
    localparam int unsigned RECIP6 = 683;

    logic [SIZE_W-1:0]    table_size_reg;
    logic [SIZE_W-1:0]    size_eff;
    logic [SIZE_W-1:0]    limit_reg, limit_next;
    logic [2*SIZE_W-1:0]  prod6;

    cmd_t   f_cmd;
    logic   f_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    cmd_t   q_head;

    // config channel is always open; writes must happen only while idle (not enforced here)
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= SIZE_W'(1024);
        else if (cfg.valid)
            table_size_reg <= cfg.data;
    end

    // saturate the configured size into the legal range
    always_comb
    begin
        if (table_size_reg < SIZE_W'(MIN_SIZE))
            size_eff = SIZE_W'(MIN_SIZE);
        else if (table_size_reg > SIZE_W'(MAXSZ))
            size_eff = SIZE_W'(MAXSZ);
        else
            size_eff = table_size_reg;
    end

    // load limit 5*(size/6)-1, registered; used only deep in the engine
    assign prod6      = size_eff * SIZE_W'(RECIP6);
    assign limit_next = SIZE_W'(prod6[2*SIZE_W-1:12]) * SIZE_W'(5) - SIZE_W'(1);

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
    end

    lph_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .size   (size_eff),
        .req    (req),
        .q_cmd  (f_cmd),
        .q_push (f_push),
        .q_full (q_full)
    );

    lph_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    lph_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .size    (size_eff),
        .limit   (limit_reg),
        .q_valid (q_valid),
        .q_cmd   (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
